// ===== src/hwrl_pkg.sv =====
// Shared types, constants and helpers for the heartbeat watchdog recovery limiter.
`default_nettype none

package hwrl_pkg;

  // Recovery ring depth and time stamp width.
  localparam int unsigned MaxRecoveries = 3;
  localparam int unsigned TimeBits      = 32;
  localparam int unsigned PtrW          = (MaxRecoveries > 1) ? $clog2(MaxRecoveries) : 1;
  localparam int unsigned CntW          = $clog2(MaxRecoveries + 1);

  // The reported count saturates at three.
  localparam logic [1:0] CountSat = 2'd3;
  localparam logic [1:0] FailCount =
      (MaxRecoveries > 3) ? CountSat : 2'(MaxRecoveries);

  typedef logic [TimeBits-1:0] stamp_t;

  // Configuration register reset values.
  localparam logic [31:0] SoftReset   = 32'd2000;
  localparam logic [31:0] HardReset   = 32'd5000;
  localparam logic [31:0] GraceReset  = 32'd10000;
  localparam logic [31:0] WindowReset = 32'd300000;

  typedef enum logic [1:0] {
    CfgSoft   = 2'd0,
    CfgHard   = 2'd1,
    CfgGrace  = 2'd2,
    CfgWindow = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ReqCheck   = 2'd0,
    ReqRestart = 2'd1,
    ReqEnable  = 2'd2,
    ReqClear   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    StallNone   = 2'd0,
    StallFirst  = 2'd1,
    StallSecond = 2'd2,
    StallBoth   = 2'd3
  } stall_kind_e;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActRestart = 2'd1,
    ActFail    = 2'd2
  } action_e;

  // Clamp a ring count to the two bit reported range.
  function automatic logic [1:0] sat_count(input logic [CntW-1:0] cnt);
    logic [1:0] res;
    if (int'(cnt) > 3) begin
      res = CountSat;
    end else begin
      res = 2'(cnt);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/hwrl_if.sv =====
// Request and result channel interfaces for the heartbeat watchdog recovery limiter.
`default_nettype none

interface hwrl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic        capturing;
  logic [31:0] first_age_ms;
  logic        first_age_valid;
  logic [31:0] second_age_ms;
  logic        second_age_valid;
  logic        enable_value;

  modport source (
    output valid, req_type, now_ms, capturing, first_age_ms, first_age_valid,
           second_age_ms, second_age_valid, enable_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, capturing, first_age_ms, first_age_valid,
           second_age_ms, second_age_valid, enable_value,
    output ready
  );
endinterface

interface hwrl_out_if;
  logic       valid;
  logic       ready;
  logic       first_warn;
  logic       second_warn;
  logic [1:0] stall_kind;
  logic [1:0] action;
  logic [1:0] recent_recoveries;
  logic       monitor_on;

  modport source (
    output valid, first_warn, second_warn, stall_kind, action, recent_recoveries,
           monitor_on,
    input  ready
  );
  modport sink (
    input  valid, first_warn, second_warn, stall_kind, action, recent_recoveries,
           monitor_on,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/heartbeat_watchdog_recovery_limiter.sv =====
// Top level of the heartbeat watchdog recovery limiter: request register, decision logic, result register.
`default_nettype none

// The block supervises two worker heartbeats and turns every request into exactly one result.
// A request is captured in an input register, evaluated by a single pass of compare and count
// logic against the watchdog state, and the result lands in an output register; a new request
// is taken every cycle while the result side keeps taking results, and a held result stalls
// the request side. A request waits in the input register while the result register is held.
// The path from request register to result register (four 32-bit age compares, the grace test
// and the window test of each recovery stamp) sets the clock limit. A check request is skipped
// while monitoring is disabled or inside the grace period after a restart notice; otherwise it
// flags soft-threshold warnings once per crossing and, on a hard stall, disables monitoring,
// stores the current tick in a ring of recovery stamps and asks for a restart, or reports
// permanent failure once the number of stamps inside the recovery window reaches the limit.
// Thresholds, grace period and window are written over the APB port; the user must write them
// only while no request is in flight, as the block itself does not enforce it.
module heartbeat_watchdog_recovery_limiter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  hwrl_in_if.sink          req_i,
  hwrl_out_if.source       rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import hwrl_pkg::*;

  // Configuration registers.
  logic [31:0] soft_q, hard_q, grace_q, window_q;
  cfg_idx_e    cfg_idx;
  logic        cfg_wr;

  // Request register.
  logic        in_vld_q;
  req_type_e   req_type_q;
  stamp_t      now_q;
  logic        capturing_q;
  logic [31:0] first_age_q, second_age_q;
  logic        first_age_vld_q, second_age_vld_q;
  logic        enable_value_q;

  // Watchdog state.
  logic           mon_en_q, mon_en_d;
  logic           grace_q_act, grace_d_act;
  stamp_t         restart_stamp_q, restart_stamp_d;
  stamp_t         stamp_q [MaxRecoveries];
  stamp_t         stamp_d [MaxRecoveries];
  logic [MaxRecoveries-1:0] stamp_vld_q, stamp_vld_d;
  logic [PtrW-1:0] ptr_q, ptr_d, ptr_wr;
  logic           first_warned_q, first_warned_d;
  logic           second_warned_q, second_warned_d;

  // Result register.
  logic        out_vld_q;
  logic        first_warn_q, first_warn_d;
  logic        second_warn_q, second_warn_d;
  stall_kind_e stall_kind_q, stall_kind_d;
  action_e     action_q, action_d;
  logic [1:0]  recent_q, recent_d;

  // Decision intermediates.
  logic           advance;
  logic           run;
  logic           soft1, soft2, stall1, stall2;
  logic [CntW-1:0] cnt;

  // A request moves from the input register to the result register when the result
  // register is free or being emptied in the same cycle.
  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  // ------------------------------------------------------------------------------------------
  // APB configuration port: writes complete in the access phase, reads are combinational.
  // ------------------------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      CfgSoft:   prdata = soft_q;
      CfgHard:   prdata = hard_q;
      CfgGrace:  prdata = grace_q;
      CfgWindow: prdata = window_q;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_q   <= SoftReset;
      hard_q   <= HardReset;
      grace_q  <= GraceReset;
      window_q <= WindowReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CfgSoft:   soft_q   <= pwdata;
        CfgHard:   hard_q   <= pwdata;
        CfgGrace:  grace_q  <= pwdata;
        CfgWindow: window_q <= pwdata;
        default:   ;
      endcase
    end
  end

  // ------------------------------------------------------------------------------------------
  // Request register. The payload needs no reset; only the valid flag does.
  // ------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q       <= req_type_e'(req_i.req_type);
      now_q            <= stamp_t'(req_i.now_ms);
      capturing_q      <= req_i.capturing;
      first_age_q      <= req_i.first_age_ms;
      first_age_vld_q  <= req_i.first_age_valid;
      second_age_q     <= req_i.second_age_ms;
      second_age_vld_q <= req_i.second_age_valid;
      enable_value_q   <= req_i.enable_value;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Decision logic: one pass over the registered request and the current state.
  // ------------------------------------------------------------------------------------------
  assign soft1  = first_age_vld_q  && (first_age_q  > soft_q);
  assign soft2  = second_age_vld_q && (second_age_q > soft_q);
  assign stall1 = first_age_vld_q  && (first_age_q  > hard_q);
  assign stall2 = second_age_vld_q && (second_age_q > hard_q);

  // A stale ring pointer wraps to the first slot before it is used.
  assign ptr_wr = (int'(ptr_q) >= MaxRecoveries) ? '0 : ptr_q;

  always_comb begin
    mon_en_d        = mon_en_q;
    grace_d_act     = grace_q_act;
    restart_stamp_d = restart_stamp_q;
    stamp_d         = stamp_q;
    stamp_vld_d     = stamp_vld_q;
    ptr_d           = ptr_q;
    first_warned_d  = first_warned_q;
    second_warned_d = second_warned_q;
    first_warn_d    = 1'b0;
    second_warn_d   = 1'b0;
    stall_kind_d    = StallNone;
    action_d        = ActNone;
    run             = 1'b0;

    case (req_type_q)
      ReqRestart: begin
        restart_stamp_d = now_q;
        grace_d_act     = 1'b1;
        mon_en_d        = 1'b1;
      end
      ReqEnable: begin
        mon_en_d = enable_value_q;
      end
      ReqClear: begin
        stamp_vld_d = '0;
        ptr_d       = '0;
        for (int i = 0; i < MaxRecoveries; i++) begin
          stamp_d[i] = '0;
        end
      end
      ReqCheck: begin
        if (mon_en_q) begin
          run = 1'b1;
          if (grace_q_act) begin
            if (stamp_t'(now_q - restart_stamp_q) < grace_q) begin
              run = 1'b0;
            end else begin
              grace_d_act = 1'b0;
            end
          end
          // Not capturing drops both warned flags and ends the check.
          if (run && !capturing_q) begin
            first_warned_d  = 1'b0;
            second_warned_d = 1'b0;
            run             = 1'b0;
          end
          if (run) begin
            first_warn_d    = soft1 && !first_warned_q;
            second_warn_d   = soft2 && !second_warned_q;
            first_warned_d  = soft1;
            second_warned_d = soft2;
            if (stall1 || stall2) begin
              stall_kind_d    = stall_kind_e'({stall2, stall1});
              mon_en_d        = 1'b0;
              stamp_d[ptr_wr]     = now_q;
              stamp_vld_d[ptr_wr] = 1'b1;
              ptr_d = (int'(ptr_wr) == MaxRecoveries - 1) ? '0 : ptr_wr + 1'b1;
              first_warned_d  = 1'b0;
              second_warned_d = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    // Count stamps inside the window after this request's ring update.
    cnt = '0;
    for (int i = 0; i < MaxRecoveries; i++) begin
      if (stamp_vld_d[i] && (stamp_t'(now_q - stamp_d[i]) < window_q)) begin
        cnt = cnt + 1'b1;
      end
    end
    if (stall_kind_d != StallNone) begin
      action_d = (int'(cnt) >= MaxRecoveries) ? ActFail : ActRestart;
    end
    recent_d = sat_count(cnt);
  end

  // ------------------------------------------------------------------------------------------
  // Watchdog state, updated as a request moves into the result register.
  // ------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_en_q        <= 1'b1;
      grace_q_act     <= 1'b0;
      restart_stamp_q <= '0;
      stamp_vld_q     <= '0;
      ptr_q           <= '0;
      first_warned_q  <= 1'b0;
      second_warned_q <= 1'b0;
      for (int i = 0; i < MaxRecoveries; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (advance) begin
      mon_en_q        <= mon_en_d;
      grace_q_act     <= grace_d_act;
      restart_stamp_q <= restart_stamp_d;
      stamp_q         <= stamp_d;
      stamp_vld_q     <= stamp_vld_d;
      ptr_q           <= ptr_d;
      first_warned_q  <= first_warned_d;
      second_warned_q <= second_warned_d;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Result register.
  // ------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      first_warn_q  <= first_warn_d;
      second_warn_q <= second_warn_d;
      stall_kind_q  <= stall_kind_d;
      action_q      <= action_d;
      recent_q      <= recent_d;
    end
  end

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.first_warn        = first_warn_q;
  assign rsp_o.second_warn       = second_warn_q;
  assign rsp_o.stall_kind        = stall_kind_q;
  assign rsp_o.action            = action_q;
  assign rsp_o.recent_recoveries = recent_q;
  // The enable after this request is the state register itself, loaded in the same cycle.
  assign rsp_o.monitor_on        = mon_en_q;

  // ------------------------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------------------------

  // A stall always leaves monitoring disabled.
  a_stall_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (stall_kind_d != StallNone) |=> !mon_en_q)
    else $error("stall did not disable monitoring");

  // A permanent failure result always reports a full window count.
  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (action_q == ActFail) |-> (recent_q == FailCount))
    else $error("failure reported without a full recovery count");

  // A request waiting in the input register keeps its tick until it moves on.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(now_q))
    else $error("held request lost or changed");

  // An action is given exactly for results of checks that find a hard stall.
  a_action_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((action_q == ActNone) == (stall_kind_q == StallNone)))
    else $error("action and stall kind disagree");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the heartbeat watchdog recovery limiter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hwrl_pkg::*;

  // The run ends if no request, result or register access moves for this many cycles.
  localparam int unsigned QuietLimit = 5000;
  // Length of the long result-side hold-off used to back the block up.
  localparam int unsigned HoldOffCycles = 400;

  // One request as the sender offers it.
  typedef struct packed {
    req_type_e   kind;
    logic [31:0] now;
    logic        capturing;
    logic [31:0] age1;
    logic        v1;
    logic [31:0] age2;
    logic        v2;
    logic        en;
  } heartbeat_req_t;

  // One result as the block should report it.
  typedef struct packed {
    logic        w1;
    logic        w2;
    stall_kind_e stall;
    action_e     act;
    logic [1:0]  recent;
    logic        mon;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hwrl_in_if  req_if ();
  hwrl_out_if rsp_if ();

  heartbeat_watchdog_recovery_limiter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Watchdog model state. The thresholds mirror the register file and are only
  // updated while nothing is in flight, so the prediction made at acceptance
  // always sees the same settings as the block.
  // ---------------------------------------------------------------------------
  logic [31:0] soft_ms   = SoftReset;
  logic [31:0] hard_ms   = HardReset;
  logic [31:0] grace_ms  = GraceReset;
  logic [31:0] window_ms = WindowReset;

  logic        monitor_en = 1'b1;
  logic        grace_on   = 1'b0;
  stamp_t      restart_ms = '0;
  stamp_t      ring_stamp [MaxRecoveries];
  logic        ring_ok    [MaxRecoveries];
  int unsigned ring_next  = 0;
  logic        warned1    = 1'b0;
  logic        warned2    = 1'b0;

  initial begin
    for (int i = 0; i < MaxRecoveries; i++) begin
      ring_stamp[i] = '0;
      ring_ok[i]    = 1'b0;
    end
  end

  // Results predicted for accepted requests, oldest first.
  verdict_t    expected_q [$];
  int unsigned mismatches = 0;

  // Stimulus bookkeeping: the running millisecond tick, its largest step per
  // request, the remaining length of the current sender burst, and the number
  // of long hold-offs the tests have asked the result side for.
  logic [31:0] tick_ms    = '0;
  logic [31:0] tick_step  = 32'd50;
  int unsigned burst_left = 0;
  int unsigned hold_asked = 0;
  int unsigned quiet_cycles = 0;

  // Number of valid recovery stamps whose age at the given tick lies inside
  // the window. Ages wrap with the tick, so a stamp from just before a wrap
  // still counts.
  function automatic int unsigned recoveries_in_window(input stamp_t now);
    int unsigned live;
    live = 0;
    for (int i = 0; i < MaxRecoveries; i++) begin
      if (ring_ok[i] && (stamp_t'(now - ring_stamp[i]) < window_ms)) begin
        live++;
      end
    end
    return live;
  endfunction

  // Advance the watchdog model by one request and return the result the block
  // must produce for it.
  function automatic verdict_t predict_verdict(input heartbeat_req_t r);
    verdict_t    v;
    logic        checking;
    logic        stall1;
    logic        stall2;
    int unsigned live;
    v = '0;
    case (r.kind)
      ReqRestart: begin
        // A restart notice opens the grace period and turns monitoring back on.
        restart_ms = r.now;
        grace_on   = 1'b1;
        monitor_en = 1'b1;
      end
      ReqEnable: begin
        monitor_en = r.en;
      end
      ReqClear: begin
        for (int i = 0; i < MaxRecoveries; i++) begin
          ring_stamp[i] = '0;
          ring_ok[i]    = 1'b0;
        end
        ring_next = 0;
      end
      default: begin
        if (monitor_en) begin
          checking = 1'b1;
          // The first check after the grace period has run out closes it and
          // goes on as a normal check.
          if (grace_on) begin
            if (stamp_t'(r.now - restart_ms) < grace_ms) begin
              checking = 1'b0;
            end else begin
              grace_on = 1'b0;
            end
          end
          // An idle pipeline forgets any earlier warning.
          if (checking && !r.capturing) begin
            warned1  = 1'b0;
            warned2  = 1'b0;
            checking = 1'b0;
          end
          if (checking) begin
            // A warning is raised once when an age first goes above the soft
            // threshold; an invalid or young age re-arms it.
            if (r.v1 && (r.age1 > soft_ms)) begin
              if (!warned1) begin
                v.w1    = 1'b1;
                warned1 = 1'b1;
              end
            end else begin
              warned1 = 1'b0;
            end
            if (r.v2 && (r.age2 > soft_ms)) begin
              if (!warned2) begin
                v.w2    = 1'b1;
                warned2 = 1'b1;
              end
            end else begin
              warned2 = 1'b0;
            end
            stall1 = r.v1 && (r.age1 > hard_ms);
            stall2 = r.v2 && (r.age2 > hard_ms);
            if (stall1 || stall2) begin
              // A stall stops monitoring, logs the tick in the ring and asks
              // for a restart unless the window already holds the limit.
              v.stall = (stall1 && stall2) ? StallBoth : (stall1 ? StallFirst : StallSecond);
              monitor_en = 1'b0;
              ring_stamp[ring_next] = r.now;
              ring_ok[ring_next]    = 1'b1;
              ring_next = (ring_next + 1) % MaxRecoveries;
              v.act = (recoveries_in_window(r.now) >= MaxRecoveries) ? ActFail : ActRestart;
              warned1 = 1'b0;
              warned2 = 1'b0;
            end
          end
        end
      end
    endcase
    live     = recoveries_in_window(r.now);
    v.recent = (live > 3) ? CountSat : 2'(live);
    v.mon    = monitor_en;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Offer one request and return at the clock edge that accepts it. The sender
  // works in bursts; a new burst may start after a random gap, and about one
  // burst in four starts with no gap at all.
  task automatic send_request(input heartbeat_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid            <= 1'b1;
    req_if.req_type         <= r.kind;
    req_if.now_ms           <= r.now;
    req_if.capturing        <= r.capturing;
    req_if.first_age_ms     <= r.age1;
    req_if.first_age_valid  <= r.v1;
    req_if.second_age_ms    <= r.age2;
    req_if.second_age_valid <= r.v2;
    req_if.enable_value     <= r.en;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // The sender stops and waits until every predicted result has been checked,
  // then keeps watching the result side so that any stray result still shows.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic heartbeat_req_t hb_request(input req_type_e kind, input logic [31:0] now,
                                                input logic cap, input logic [31:0] age1,
                                                input logic v1, input logic [31:0] age2,
                                                input logic v2, input logic en);
    heartbeat_req_t r;
    r.kind      = kind;
    r.now       = now;
    r.capturing = cap;
    r.age1      = age1;
    r.v1        = v1;
    r.age2      = age2;
    r.v2        = v2;
    r.en        = en;
    return r;
  endfunction

  // Heartbeat ages are drawn around the current thresholds so that warnings,
  // stalls and both boundaries are hit often, with the extremes mixed in.
  function automatic logic [31:0] pick_age();
    logic [31:0] age;
    case ($urandom_range(0, 9))
      0: age = '0;
      1: age = 32'hFFFF_FFFF;
      2, 3: age = $urandom_range(0, soft_ms);
      4, 5: age = (hard_ms > soft_ms) ?
                  soft_ms + 32'd1 + 32'($urandom_range(0, hard_ms - soft_ms - 32'd1)) : soft_ms;
      6, 7: age = hard_ms + 32'd1 + 32'($urandom_range(0, 64));
      8: age = ($urandom_range(0, 1) != 0) ? soft_ms : hard_ms;
      default: age = $urandom();
    endcase
    return age;
  endfunction

  // Most requests follow a forward-running tick with a realistic mix of
  // checks and control requests; one in twenty is pure noise.
  function automatic heartbeat_req_t random_request();
    heartbeat_req_t r;
    int unsigned    pick;
    tick_ms = tick_ms + 32'($urandom_range(0, tick_step));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.kind      = req_type_e'($urandom_range(0, 3));
      r.now       = $urandom();
      r.capturing = 1'($urandom_range(0, 1));
      r.age1      = $urandom();
      r.v1        = 1'($urandom_range(0, 1));
      r.age2      = $urandom();
      r.v2        = 1'($urandom_range(0, 1));
      r.en        = 1'($urandom_range(0, 1));
    end else begin
      r.kind      = (pick < 68) ? ReqCheck : (pick < 80) ? ReqRestart :
                    (pick < 93) ? ReqEnable : ReqClear;
      r.now       = tick_ms;
      r.capturing = ($urandom_range(0, 9) != 0);
      r.age1      = pick_age();
      r.v1        = ($urandom_range(0, 7) != 0);
      r.age2      = pick_age();
      r.v2        = ($urandom_range(0, 7) != 0);
      r.en        = ($urandom_range(0, 4) != 0);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Register port. A write is followed by a read of the same register, which
  // must return the value just written.
  // ---------------------------------------------------------------------------
  task automatic write_register(input cfg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      CfgSoft:   soft_ms   = value;
      CfgHard:   hard_ms   = value;
      CfgGrace:  grace_ms  = value;
      default:   window_ms = value;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) begin
      mismatches++;
      $display("%0t: register %s read back expected %0d, actual %0d",
               $time, idx.name(), value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle, so the sender drains first.
  task automatic apply_settings(input logic [31:0] soft_lim, input logic [31:0] hard,
                                input logic [31:0] grace, input logic [31:0] window);
    wait_for_results();
    write_register(CfgSoft, soft_lim);
    write_register(CfgHard, hard);
    write_register(CfgGrace, grace);
    write_register(CfgWindow, window);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Walks the watchdog through every request type and its special cases with
  // the reset thresholds: single warnings per crossing, the boundary ages, an
  // idle pipeline, invalid ages, each stall kind, checks skipped while
  // disabled or in grace, grace running out across a tick wrap, the failure
  // limit and clearing of the ring.
  task automatic test_directed_sequence();
    send_request(hb_request(ReqCheck, 32'd0, 1'b1, 32'd0, 1'b1, 32'd0, 1'b1, 1'b0));
    send_request(hb_request(ReqCheck, 32'd10, 1'b1, 32'd2001, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_request(hb_request(ReqCheck, 32'd20, 1'b1, 32'd2001, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_request(hb_request(ReqCheck, 32'd30, 1'b1, 32'd2000, 1'b1, 32'd0, 1'b1, 1'b0));
    send_request(hb_request(ReqCheck, 32'd40, 1'b1, 32'd2500, 1'b1, 32'd3000, 1'b1, 1'b0));
    send_request(hb_request(ReqCheck, 32'd50, 1'b0, 32'd2500, 1'b1, 32'd3000, 1'b1, 1'b0));
    send_request(hb_request(ReqCheck, 32'd60, 1'b1, 32'hFFFF_FFFF, 1'b1,
                            32'hFFFF_FFFF, 1'b1, 1'b0));
    send_request(hb_request(ReqCheck, 32'd70, 1'b1, 32'hFFFF_FFFF, 1'b1,
                            32'hFFFF_FFFF, 1'b1, 1'b0));
    send_request(hb_request(ReqEnable, 32'd80, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1));
    send_request(hb_request(ReqCheck, 32'd100, 1'b1, 32'd0, 1'b1, 32'd5001, 1'b1, 1'b0));
    send_request(hb_request(ReqEnable, 32'd110, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0));
    send_request(hb_request(ReqEnable, 32'd120, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1));
    send_request(hb_request(ReqRestart, 32'd200, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0));
    send_request(hb_request(ReqCheck, 32'd300, 1'b1, 32'd9000, 1'b1, 32'd9000, 1'b1, 1'b0));
    // Exactly one grace period after the notice the check runs; a third stall
    // inside the window reaches the limit.
    send_request(hb_request(ReqCheck, 32'd10200, 1'b1, 32'd5001, 1'b1, 32'd5000, 1'b1, 1'b0));
    send_request(hb_request(ReqRestart, 32'hFFFF_FFF0, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0));
    send_request(hb_request(ReqCheck, 32'h0000_0010, 1'b1, 32'd9000, 1'b1, 32'd9000, 1'b1,
                            1'b0));
    send_request(hb_request(ReqCheck, 32'd20000, 1'b1, 32'd5000, 1'b1, 32'd5000, 1'b1, 1'b0));
    send_request(hb_request(ReqClear, 32'd20001, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b1));
    send_request(hb_request(ReqCheck, 32'd20002, 1'b1, 32'd6000, 1'b1, 32'd0, 1'b0, 1'b0));
  endtask

  // The longest grace period ends only when the tick has run a full lap less
  // one, and a window of one counts only a stamp from the same tick.
  task automatic test_register_extremes();
    apply_settings(SoftReset, HardReset, 32'hFFFF_FFFF, 32'd1);
    send_request(hb_request(ReqRestart, 32'd1000, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0));
    send_request(hb_request(ReqCheck, 32'd998, 1'b1, 32'd6000, 1'b1, 32'd0, 1'b0, 1'b0));
    send_request(hb_request(ReqCheck, 32'd999, 1'b1, 32'd6000, 1'b1, 32'd0, 1'b0, 1'b0));
    send_request(hb_request(ReqClear, 32'd999, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0));
  endtask

  // A phase of random traffic under one set of thresholds.
  task automatic test_random_traffic(input int unsigned count, input logic [31:0] soft_lim,
                                     input logic [31:0] hard, input logic [31:0] grace,
                                     input logic [31:0] window, input logic [31:0] step);
    apply_settings(soft_lim, hard, grace, window);
    tick_step = step;
    repeat (count) send_request(random_request());
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the block fills up and has to stall its request side.
  task automatic test_result_backpressure();
    apply_settings(32'd100, 32'd300, 32'd200, 32'd2000);
    tick_step = 32'd80;
    hold_asked++;
    repeat (150) send_request(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls on a pattern that switches between always
  // ready, mostly ready and mostly stalled, and honors long hold-offs.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    hold_seen    = 0;
    hold_left    = 0;
    mode         = 0;
    mode_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HoldOffCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_if.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Every accepted request is run through the model right away, in order.
  always @(posedge clk_i) begin : request_monitor
    heartbeat_req_t taken;
    if (rst_ni && req_if.valid && req_if.ready) begin
      taken.kind      = req_type_e'(req_if.req_type);
      taken.now       = req_if.now_ms;
      taken.capturing = req_if.capturing;
      taken.age1      = req_if.first_age_ms;
      taken.v1        = req_if.first_age_valid;
      taken.age2      = req_if.second_age_ms;
      taken.v2        = req_if.second_age_valid;
      taken.en        = req_if.enable_value;
      expected_q.push_back(predict_verdict(taken));
    end
  end

  function automatic void compare_field(input string name, input logic [1:0] want,
                                        input logic [1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Each accepted result is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_checker
    verdict_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding", $time);
      end else begin
        want = expected_q.pop_front();
        compare_field("first_warn", want.w1, rsp_if.first_warn);
        compare_field("second_warn", want.w2, rsp_if.second_warn);
        compare_field("stall_kind", want.stall, rsp_if.stall_kind);
        compare_field("action", want.act, rsp_if.action);
        compare_field("recent_recoveries", want.recent, rsp_if.recent_recoveries);
        compare_field("monitor_on", want.mon, rsp_if.monitor_on);
      end
    end
  end

  // Ends a hung run: register accesses count as progress too.
  always @(posedge clk_i) begin : progress_watchdog
    if (!rst_ni || psel || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
               $time, QuietLimit, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.req_type         <= ReqCheck;
    req_if.now_ms           <= '0;
    req_if.capturing        <= 1'b0;
    req_if.first_age_ms     <= '0;
    req_if.first_age_valid  <= 1'b0;
    req_if.second_age_ms    <= '0;
    req_if.second_age_valid <= 1'b0;
    req_if.enable_value     <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_sequence();
    test_register_extremes();
    // Tight thresholds with a slow tick: frequent stalls, the failure limit
    // and grace periods that run out between checks.
    test_random_traffic(550, 32'd20, 32'd50, 32'd100, 32'd1000, 32'd60);
    // Any valid nonzero age warns, nothing stalls, grace ends at once, the tick jumps freely.
    test_random_traffic(300, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Any valid nonzero age stalls and only same-tick stamps are counted.
    test_random_traffic(250, 32'hFFFF_FFFF, 32'd0, 32'd5, 32'd1, 32'd3);
    // An empty window never counts a stamp, so every stall asks for a restart.
    test_random_traffic(300, 32'd30, 32'd40, 32'd50, 32'd0, 32'd20);
    test_result_backpressure();

    wait_for_results();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hwrl_pkg.sv
src/hwrl_if.sv
src/heartbeat_watchdog_recovery_limiter.sv
tb/testbench.sv
